[rtl/bgd_pkg.sv]
// Package for the button gesture detector: widths, codes and time helpers.
// Used by button_gesture_detector and its port checker.
`timescale 1ns / 1ps

package bgd_pkg;

	localparam int TICK_BITS   = 32;
	localparam int HOLD_CODE   = 3;
	localparam int AGE_W       = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int GEST_COUNT  = 5;
	localparam int FIRED_W     = 3;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_FIELD_W = GEST_COUNT * AGE_W + FIRED_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int FIRED_LSB   = GEST_COUNT * AGE_W;

	typedef logic [TICK_BITS-1:0] tick_t;

	localparam tick_t HALF     = {1'b0, {(TICK_BITS-1){1'b1}}};
	localparam tick_t HOLD_SUB = TICK_BITS'(HOLD_CODE);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLICK_MIN  = 8'd0,
		CFG_HOLD       = 8'd1,
		CFG_DOUBLE_GAP = 8'd2,
		CFG_LISTEN     = 8'd3
	} cfg_index_t;

	typedef enum logic [FIRED_W-1:0] {
		GEST_NONE       = 3'd0,
		GEST_CLICK      = 3'd1,
		GEST_DOUBLE     = 3'd2,
		GEST_LONE       = 3'd3,
		GEST_HOLD       = 3'd4,
		GEST_CLICK_HOLD = 3'd5
	} gesture_t;

	function automatic tick_t tsub(input tick_t a, input tick_t b);
		return a - b;
	endfunction

	function automatic logic lt_half(input tick_t d);
		return d < HALF;
	endfunction

	function automatic logic is_click(input tick_t down, input logic [CFG_W-1:0] min_t,
			input logic [CFG_W-1:0] hold_t);
		return (down < HALF) && (down > TICK_BITS'(min_t)) && (down <= TICK_BITS'(hold_t));
	endfunction

	function automatic logic [AGE_W-1:0] to_age(input tick_t t);
		logic [TICK_BITS+AGE_W-1:0] ext;
		ext = {{AGE_W{1'b0}}, t};
		return ext[AGE_W-1:0];
	endfunction

endpackage

[rtl/button_gesture_detector.sv]
// Top level of the button gesture detector: input stage, edge and time state,
// gesture evaluation and result register. Depends on bgd_pkg.
`timescale 1ns / 1ps

// One item per clock cycle while the result register is not stalled. An accepted item
// is registered in the input stage; when that stage advances, the tick state, the
// auto-fire priority and the five ages are worked out in one pass and written to the
// result register. The result register holds while m_tready is low, and the input stage
// keeps accepting as long as that stage can move on.
// Configuration writes are taken at any time (cfg_ready is always high).
module button_gesture_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bgd_pkg::IN_DATA_W-1:0] s_tdata,  // [0] pressed, [1] ignore_clear
	input  logic                          s_tuser,  // [0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] clicked_age, [63:32] double_age, [95:64] lone_click_age,
	// [127:96] hold_age, [159:128] click_hold_age, [162:160] fired
	output logic [bgd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgd_pkg::CFG_W-1:0]     cfg_data
);
	import bgd_pkg::*;

	logic valid_s1, kind_s1, pressed_s1, ign_s1;
	logic adv;

	tick_t now_q, press_q, prior_press_q, release_q, prior_release_q, clear_q;
	logic  level_q;

	logic [CFG_W-1:0]      click_min_q, hold_q, double_gap_q;
	logic [GEST_COUNT-1:0] listen_q;

	tick_t now_n, press_n, prior_press_n, release_n, prior_release_n, clear_n;
	logic  level_n, rise, fall;

	tick_t                 age_raw [GEST_COUNT];
	logic [GEST_COUNT-1:0] cond;
	logic                  clr_fire, clr_out, found;
	gesture_t              fired;
	logic [AGE_W-1:0]      age_out [GEST_COUNT];

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	tick_t d1, d2_down, d2_up, d2_down2, d3_down, d3_up, d4_up, d4_down;
	tick_t d5_down, d5_up, d5_down2;

	assign adv       = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1    <= s_tuser;
			pressed_s1 <= s_tdata[0];
			ign_s1     <= s_tdata[1];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_min_q  <= CFG_W'(10);
			hold_q       <= CFG_W'(1000);
			double_gap_q <= CFG_W'(200);
			listen_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLICK_MIN:  click_min_q  <= cfg_data;
				CFG_HOLD:       hold_q       <= cfg_data;
				CFG_DOUBLE_GAP: double_gap_q <= cfg_data;
				CFG_LISTEN:     listen_q     <= cfg_data[GEST_COUNT-1:0];
				default: ;
			endcase
		end
	end

	// next time and edge state
	always_comb begin
		now_n           = kind_s1 ? now_q : now_q + TICK_BITS'(1);
		rise            = !kind_s1 && pressed_s1 && !level_q;
		fall            = !kind_s1 && !pressed_s1 && level_q;
		level_n         = kind_s1 ? level_q : pressed_s1;
		press_n         = rise ? now_n : press_q;
		prior_press_n   = rise ? press_q : prior_press_q;
		release_n       = fall ? now_n : release_q;
		prior_release_n = fall ? release_q : prior_release_q;
	end

	// gesture conditions and raw ages
	always_comb begin
		d1       = tsub(release_n, press_n);
		d2_down  = tsub(prior_release_n, prior_press_n);
		d2_up    = tsub(press_n, prior_release_n);
		d2_down2 = d1;
		d3_down  = d1;
		d3_up    = tsub(now_n, release_n);
		d4_up    = tsub(press_n, release_n);
		d4_down  = tsub(now_n, press_n);
		d5_down  = tsub(release_n, prior_press_n);
		d5_up    = d4_up;
		d5_down2 = d4_down;

		cond[0] = is_click(d1, click_min_q, hold_q);
		cond[1] = is_click(d2_down, click_min_q, hold_q) && lt_half(d2_up)
			&& (d2_up <= TICK_BITS'(double_gap_q)) && is_click(d2_down2, click_min_q, hold_q);
		cond[2] = is_click(d3_down, click_min_q, hold_q) && lt_half(d3_up)
			&& (d3_up > TICK_BITS'(double_gap_q));
		cond[3] = (d4_up != '0) && lt_half(d4_up) && lt_half(d4_down)
			&& (d4_down > TICK_BITS'(hold_q));
		cond[4] = is_click(d5_down, click_min_q, hold_q) && (d5_up != '0) && lt_half(d5_up)
			&& (d5_up <= TICK_BITS'(double_gap_q)) && lt_half(d5_down2)
			&& (d5_down2 > TICK_BITS'(hold_q));

		age_raw[0] = d3_up;
		age_raw[1] = d3_up;
		age_raw[2] = d3_up;
		age_raw[3] = tsub(d4_down, HOLD_SUB);
		age_raw[4] = tsub(d5_down2, HOLD_SUB);
	end

	// auto fire in gesture order, then reported ages
	always_comb begin
		clr_fire = lt_half(tsub(press_n, clear_q));
		found    = 1'b0;
		fired    = GEST_NONE;
		for (int g = 0; g < GEST_COUNT; g++) begin
			if (!found && !kind_s1 && clr_fire && listen_q[g] && cond[g]
					&& (age_raw[g] != '0)) begin
				found = 1'b1;
				fired = gesture_t'(FIRED_W'(g + 1));
			end
		end
		if (kind_s1 || found) begin
			clear_n = now_n;
		end else begin
			clear_n = clear_q;
		end
		clr_out = ign_s1 || lt_half(tsub(press_n, clear_n));
		for (int g = 0; g < GEST_COUNT; g++) begin
			age_out[g] = (clr_out && cond[g]) ? to_age(age_raw[g]) : '0;
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q           <= '0;
			level_q         <= 1'b0;
			press_q         <= '0;
			prior_press_q   <= '0;
			release_q       <= '0;
			prior_release_q <= '0;
			clear_q         <= TICK_BITS'(1);
		end else if (adv) begin
			now_q           <= now_n;
			level_q         <= level_n;
			press_q         <= press_n;
			prior_press_q   <= prior_press_n;
			release_q       <= release_n;
			prior_release_q <= prior_release_n;
			clear_q         <= clear_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {(OUT_DATA_W - OUT_FIELD_W)'(0), fired,
				age_out[4], age_out[3], age_out[2], age_out[1], age_out[0]};
		end
	end

endmodule

[rtl/bgd_checker.sv]
// Port assertions for button_gesture_detector, attached by the bind below.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bgd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import bgd_pkg::*;

	logic [FIRED_W-1:0] fired;
	logic [AGE_W-1:0]   clicked_age, hold_age;

	assign fired       = m_tdata[FIRED_LSB +: FIRED_W];
	assign clicked_age = m_tdata[0 +: AGE_W];
	assign hold_age    = m_tdata[3*AGE_W +: AGE_W];

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a new result needs an earlier input transfer
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without input transfer");

	a_fired_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (fired <= FIRED_W'(GEST_CLICK_HOLD)))
		else $error("fired code out of range");

	// a click needs release after press, a hold needs press after release
	a_click_vs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !((clicked_age != '0) && (hold_age != '0)))
		else $error("click and hold reported together");

endmodule

bind button_gesture_detector bgd_props u_bgd_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/bgd_checker.sv]
// Port checker for button_gesture_detector: predicts every result from the accepted
// input and configuration transfers and compares it with the output stream.
// Depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bgd_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bgd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgd_pkg::CFG_W-1:0]      cfg_data,
	output int                             fails,
	output int                             pending
);
	import bgd_pkg::*;

	typedef logic [OUT_FIELD_W-1:0] report_t;

	tick_t now_t, press_t, prior_press_t, release_t, prior_release_t, clear_t;
	logic level_q;
	logic [CFG_W-1:0] click_min, hold_lim, dbl_gap;
	logic [GEST_COUNT-1:0] listen;
	report_t gesture_reports[$];

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic logic click_len_ok(input tick_t down);
		return (down < HALF) && (down > tick_t'(click_min)) && (down <= tick_t'(hold_lim));
	endfunction

	function automatic tick_t gesture_age(input gesture_t g, input logic ign);
		tick_t down, up, down2, mark_gap, age;
		mark_gap = press_t - clear_t;
		age = '0;
		if (ign || mark_gap < HALF) begin
			case (g)
				GEST_CLICK: begin
					down = release_t - press_t;
					if (click_len_ok(down))
						age = now_t - release_t;
				end
				GEST_DOUBLE: begin
					down = prior_release_t - prior_press_t;
					up = press_t - prior_release_t;
					down2 = release_t - press_t;
					if (click_len_ok(down) && up < HALF && up <= tick_t'(dbl_gap) &&
							click_len_ok(down2))
						age = now_t - release_t;
				end
				GEST_LONE: begin
					down = release_t - press_t;
					up = now_t - release_t;
					if (click_len_ok(down) && up < HALF && up > tick_t'(dbl_gap))
						age = up;
				end
				GEST_HOLD: begin
					up = press_t - release_t;
					down = now_t - press_t;
					if (up != 0 && up < HALF && down < HALF && down > tick_t'(hold_lim))
						age = down - tick_t'(HOLD_CODE);
				end
				GEST_CLICK_HOLD: begin
					down = release_t - prior_press_t;
					up = press_t - release_t;
					down2 = now_t - press_t;
					if (click_len_ok(down) && up != 0 && up < HALF &&
							up <= tick_t'(dbl_gap) && down2 < HALF &&
							down2 > tick_t'(hold_lim))
						age = down2 - tick_t'(HOLD_CODE);
				end
				default: ;
			endcase
		end
		return age;
	endfunction

	function automatic report_t step_gestures(input logic kind, input logic lvl,
			input logic ign);
		report_t rep;
		gesture_t hit;
		tick_t age;
		int g;
		hit = GEST_NONE;
		if (kind) begin
			clear_t = now_t;
		end else begin
			now_t = now_t + 1'b1;
			if (lvl && !level_q) begin
				prior_press_t = press_t;
				press_t = now_t;
			end
			if (!lvl && level_q) begin
				prior_release_t = release_t;
				release_t = now_t;
			end
			level_q = lvl;
			for (g = 1; g <= GEST_COUNT; g++) begin
				if (hit == GEST_NONE && listen[g-1] &&
						gesture_age(gesture_t'(g), 1'b0) != 0) begin
					clear_t = now_t;
					hit = gesture_t'(g);
				end
			end
		end
		for (g = 1; g <= GEST_COUNT; g++) begin
			age = gesture_age(gesture_t'(g), ign);
			rep[(g-1)*AGE_W +: AGE_W] = age[AGE_W-1:0];
		end
		rep[FIRED_LSB +: FIRED_W] = hit;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want, got;
		gesture_t gn;
		int g;
		if (!arst_n) begin
			now_t = '0;
			level_q = 1'b0;
			press_t = '0;
			prior_press_t = '0;
			release_t = '0;
			prior_release_t = '0;
			clear_t = tick_t'(1);
			click_min = 16'd10;
			hold_lim = 16'd1000;
			dbl_gap = 16'd200;
			listen = '0;
			gesture_reports.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_FIELD_W-1:0];
				if (gesture_reports.size() == 0) begin
					$display("%0t bgd_checker: result with nothing expected, actual %h",
						$time, got);
					fails++;
				end else begin
					want = gesture_reports.pop_front();
					for (g = 1; g <= GEST_COUNT; g++) begin
						gn = gesture_t'(g);
						if (got[(g-1)*AGE_W +: AGE_W] !== want[(g-1)*AGE_W +: AGE_W]) begin
							$display("%0t bgd_checker: %s age expected %h actual %h",
								$time, gn.name(), want[(g-1)*AGE_W +: AGE_W],
								got[(g-1)*AGE_W +: AGE_W]);
							fails++;
						end
					end
					if (got[FIRED_LSB +: FIRED_W] !== want[FIRED_LSB +: FIRED_W]) begin
						$display("%0t bgd_checker: fired expected %h actual %h", $time,
							want[FIRED_LSB +: FIRED_W], got[FIRED_LSB +: FIRED_W]);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CLICK_MIN:  click_min = cfg_data;
					CFG_HOLD:       hold_lim = cfg_data;
					CFG_DOUBLE_GAP: dbl_gap = cfg_data;
					CFG_LISTEN:     listen = cfg_data[GEST_COUNT-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				gesture_reports.push_back(step_gestures(s_tuser, s_tdata[0], s_tdata[1]));
		end
		pending = gesture_reports.size();
	end

endmodule

[verif/tb.sv]
// Testbench top for button_gesture_detector: clock, reset, input and configuration
// stimulus, random output back-pressure and the final verdict.
// Depends on bgd_pkg and bgd_checker.
`timescale 1ns / 1ps

module tb;
	import bgd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int fails;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int items_sent = 0;
	int press_cap = 4;
	int gap_cap = 4;

	button_gesture_detector dut (.*);
	bgd_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic push_item(input logic kind, input logic lvl, input logic ign);
		logic took;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(IN_DATA_W-2){1'b0}}, ign, lvl};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// hold off until every expected result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int cmin, input int hold, input int gap, input int mask);
		drain();
		cfg_write(CFG_CLICK_MIN, CFG_W'(cmin));
		cfg_write(CFG_HOLD, CFG_W'(hold));
		cfg_write(CFG_DOUBLE_GAP, CFG_W'(gap));
		cfg_write(CFG_LISTEN, CFG_W'(mask));
		cfg_write(CFG_IDX_W'($urandom_range(4, 255)), CFG_W'($urandom));
		cfg_valid <= 1'b0;
		press_cap = (hold > 36) ? 40 : hold + 4;
		gap_cap = (gap > 36) ? 40 : gap + 4;
	endtask

	task automatic gesture_burst();
		int pick, presses, n, i, j;
		pick = $urandom_range(9);
		if (pick < 7) begin
			presses = $urandom_range(1, 3);
			for (i = 0; i < presses; i++) begin
				n = $urandom_range(1, press_cap);
				for (j = 0; j < n; j++)
					push_item(1'b0, 1'b1, 1'($urandom_range(1)));
				n = $urandom_range(1, gap_cap);
				for (j = 0; j < n; j++) begin
					if ($urandom_range(19) == 0)
						push_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
					push_item(1'b0, 1'b0, 1'($urandom_range(1)));
				end
			end
		end else if (pick == 7) begin
			push_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				push_item($urandom_range(3) == 0, 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	task automatic run_random(input int count);
		int stop_at, pause_at;
		logic paused;
		stop_at = items_sent + count;
		pause_at = items_sent + count / 2;
		paused = 1'b0;
		while (items_sent < stop_at) begin
			gesture_burst();
			if (!paused && items_sent >= pause_at) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin : stimulus
		// {kind, pressed, ignore_clear}: click, lone click, double click,
		// click then hold, clear while held
		logic [2:0] directed [26] = '{3'b000, 3'b101, 3'b010, 3'b010, 3'b010, 3'b001,
			3'b000, 3'b000, 3'b001, 3'b000, 3'b010, 3'b010, 3'b000, 3'b010, 3'b011,
			3'b000, 3'b010, 3'b010, 3'b010, 3'b011, 3'b010, 3'b010, 3'b010, 3'b100,
			3'b011, 3'b001};
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 25;
		rx_idle_pct = 79;
		configure(1, 4, 3, 0);
		for (k = 0; k < 26; k++)
			push_item(directed[k][2], directed[k][1], directed[k][0]);
		configure(1, 4, 3, $urandom);
		run_random(320);
		configure(0, 0, 0, 'h1F);
		run_random(320);

		tx_idle_pct = 79;
		rx_idle_pct = 25;
		configure(3, 12, 6, $urandom);
		run_random(320);
		configure(65535, 65535, 65535, 'h1F);
		run_random(320);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(2, 7, 65535, $urandom);
		run_random(320);
		configure(5, 20, 10, $urandom);
		run_random(320);

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
